// File: src/dngd_pkg.sv
// ============================================================================
// dngd_pkg
// Shared types and calendar constants for the day number to Gregorian date
// converter.
// ============================================================================
package dngd_pkg;

	// Field widths of one transaction.
	localparam int DAY_NUMBER_W = 32;
	localparam int YEAR_W       = 24;
	localparam int MONTH_W      = 4;
	localparam int DAY_W        = 5;

	typedef logic signed [DAY_NUMBER_W-1:0] day_number_t;
	typedef logic signed [YEAR_W-1:0]       year_t;
	typedef logic        [MONTH_W-1:0]      month_t;
	typedef logic        [DAY_W-1:0]        day_t;

	// Calendar constants. Day numbers are counted from 1 March of year 0.
	localparam int EPOCH_MAR1_Y0 = 1721120;
	localparam int DAYS_YEAR     = 365;
	localparam int DAYS_4Y       = 4 * DAYS_YEAR + 1;
	localparam int DAYS_100Y     = 25 * DAYS_4Y - 1;
	localparam int DAYS_400Y     = 4 * DAYS_100Y + 1;
	localparam int DAYS_5MON     = 153;
	localparam int DAYS_2MON     = 61;
	localparam int DAYS_LONG_MON = 31;
	localparam int YEARS_400     = 400;
	localparam int YEARS_100     = 100;
	localparam int YEARS_4       = 4;
	localparam int MONTHS_YEAR   = 12;
	localparam int MONTH_FEB     = 2;
	localparam int DAY_LEAP      = 29;
	// Month index 0 is March, so index plus this offset is the calendar month.
	localparam int MONTH_OFFSET  = 3;

	// The day count is biased by a whole number of 400-year cycles so that
	// every 32-bit input becomes a non-negative 33-bit value.
	localparam int     CYCLE_BIAS = 14720;
	localparam longint JDN_BIAS   = longint'(CYCLE_BIAS) * longint'(DAYS_400Y)
		- longint'(EPOCH_MAR1_Y0);
	localparam int     YEAR_BIAS  = CYCLE_BIAS * YEARS_400;

	// Internal widths.
	localparam int U_W    = 33;	// biased day count
	localparam int CYC_W  = 15;	// number of 400-year cycles
	localparam int R400_W = 18;	// days within a 400-year cycle
	localparam int R100_W = 16;	// days within a 100-year cycle
	localparam int R4_W   = 11;	// days within a 4-year cycle
	localparam int R1_W   = 9;	// days within a March-based year
	localparam int R5_W   = 8;	// days within a five-month group
	localparam int R2_W   = 6;	// days within a two-month group

	// Reciprocal of the 400-year cycle length. The low bits of the biased
	// count are dropped, which keeps the product narrow; the quotient
	// estimate is then exact or one low.
	localparam int     U_DROP            = 10;
	localparam int     RECIP_400Y_SHIFT  = 40;
	localparam longint RECIP_400Y        =
		(longint'(1) << RECIP_400Y_SHIFT) / longint'(DAYS_400Y);
	localparam int     RECIP_400Y_W      = U_W - U_DROP;

	// Rounded-up reciprocal of the 4-year cycle length, exact for every
	// 16-bit dividend.
	localparam int     RECIP_4Y_SHIFT    = 27;
	localparam longint RECIP_4Y          =
		((longint'(1) << RECIP_4Y_SHIFT) + longint'(DAYS_4Y) - 1) / longint'(DAYS_4Y);
	localparam int     RECIP_4Y_W        = 17;
	localparam int     C4_W              = 5;

endpackage

// File: src/day_number_to_gregorian_date_top.sv
// ============================================================================
// day_number_to_gregorian_date_top
// Converts a signed Julian Day number to the proleptic Gregorian year, month
// and day. A new day number is taken on every cycle that start is high; busy
// never rises. Each transaction comes out on year, month and day with done
// high for one cycle, in order, after passing through the eleven-stage
// pipeline; its two reciprocal multipliers (of the 400-year cycle and of
// the 4-year cycle) each have a stage of their own. The receiver cannot
// stall the block, and none is needed: one result leaves per cycle at most,
// as fast as items enter.
// ============================================================================
module day_number_to_gregorian_date_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  dngd_pkg::day_number_t  day_number,
	output logic                   done,
	output dngd_pkg::year_t        year,
	output dngd_pkg::month_t       month,
	output dngd_pkg::day_t         day
);

	import dngd_pkg::*;

	localparam int PROD400_W = 2 * RECIP_400Y_W;
	localparam int Q400_LSB  = RECIP_400Y_SHIFT - U_DROP;
	localparam int REM0_W    = R400_W + 1;
	localparam int PROD4_W   = R100_W + RECIP_4Y_W;

	// Valid bits that travel with each stage.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;

	// Stage payload registers.
	logic [U_W-1:0]    u_s1;
	logic [REM0_W-1:0] ulow_s2;
	logic [CYC_W-1:0]  q_s2, q_s3, q_s4;
	logic [REM0_W-1:0] rem0_s3;
	logic [R400_W-1:0] rem_s4;
	logic [R100_W-1:0] rem100_s5, rem100_s6;
	logic [2:0]        c100_s5;
	logic [C4_W-1:0]   c4_s6;
	logic [R4_W-1:0]   rem4_s7;
	logic [R1_W-1:0]   rem1_s8;
	logic [1:0]        c5_s9, c5_s10;
	logic [R5_W-1:0]   r5_s9;
	logic [1:0]        c2_s10;
	logic [R2_W-1:0]   r2_s10;
	year_t             y_s5, y_s6, y_s7, y_s8, y_s9, y_s10, y_s11;
	logic              leap_s5, leap_s6, leap_s7, leap_s8, leap_s9, leap_s10;
	month_t            month_s11;
	day_t              day_s11;

	// Combinational signals between stages.
	logic signed [U_W:0]   u_wide_1;
	logic [PROD400_W-1:0]  prod400_2;
	logic [U_W:0]          qmul_3;
	logic [R400_W-1:0]     rem_4;
	logic [CYC_W-1:0]      q_4;
	logic                  ge1_5, ge2_5, ge3_5, ge4_5;
	logic [2:0]            c100_5;
	logic [R400_W-1:0]     off100_5;
	logic [PROD4_W-1:0]    prod4_6;
	logic [R100_W-1:0]     rem4_wide_7;
	logic [2:0]            c1_8;
	logic [R4_W-1:0]       off1_8;
	logic [1:0]            c5_9;
	logic [R1_W-1:0]       off5_9;
	logic [1:0]            c2_10;
	logic [R5_W-1:0]       off2_10;
	logic                  c31_11;
	logic [3:0]            m0_11;
	logic [R2_W-1:0]       dom0_11;

	// The pipeline never holds an item back.
	assign busy = 1'b0;

	// Stage 1: bias the day count into a non-negative value.
	assign u_wide_1 = (U_W+1)'(day_number) + (U_W+1)'(JDN_BIAS);

	// Stage 2: estimate the number of 400-year cycles by a reciprocal.
	assign prod400_2 = PROD400_W'(u_s1[U_W-1:U_DROP]) * PROD400_W'(RECIP_400Y);

	// Stage 3: remainder of the estimate; it is below twice the cycle length,
	// so the low bits of both operands suffice.
	assign qmul_3 = (U_W+1)'(q_s2) * (U_W+1)'(DAYS_400Y);

	// Stage 4: correct an estimate that came out one low.
	always_comb begin
		if (rem0_s3 >= REM0_W'(DAYS_400Y)) begin
			rem_4 = R400_W'(rem0_s3 - REM0_W'(DAYS_400Y));
			q_4   = q_s3 + CYC_W'(1);
		end else begin
			rem_4 = R400_W'(rem0_s3);
			q_4   = q_s3;
		end
	end

	// Stage 5: split the 400-year cycle into centuries. The last day of the
	// cycle is a fifth century of one day: the leap day of a 400-year cycle.
	assign ge1_5 = rem_s4 >= R400_W'(DAYS_100Y);
	assign ge2_5 = rem_s4 >= R400_W'(2 * DAYS_100Y);
	assign ge3_5 = rem_s4 >= R400_W'(3 * DAYS_100Y);
	assign ge4_5 = rem_s4 >= R400_W'(4 * DAYS_100Y);
	assign c100_5 = 3'(ge1_5) + 3'(ge2_5) + 3'(ge3_5) + 3'(ge4_5);

	always_comb begin
		case (c100_5)
			3'd0:    off100_5 = '0;
			3'd1:    off100_5 = R400_W'(DAYS_100Y);
			3'd2:    off100_5 = R400_W'(2 * DAYS_100Y);
			3'd3:    off100_5 = R400_W'(3 * DAYS_100Y);
			default: off100_5 = R400_W'(4 * DAYS_100Y);
		endcase
	end

	// Stage 6: number of 4-year cycles in the century by an exact reciprocal.
	assign prod4_6 = PROD4_W'(rem100_s5) * PROD4_W'(RECIP_4Y);

	// Stage 7: days left within the 4-year cycle.
	assign rem4_wide_7 = rem100_s6 - R100_W'(c4_s6) * R100_W'(DAYS_4Y);

	// Stage 8: whole years within the 4-year cycle. A count of four marks
	// the leap day that ends a 4-year cycle.
	always_comb begin
		if (rem4_s7 >= R4_W'(4 * DAYS_YEAR)) begin
			c1_8   = 3'd4;
			off1_8 = R4_W'(4 * DAYS_YEAR);
		end else if (rem4_s7 >= R4_W'(3 * DAYS_YEAR)) begin
			c1_8   = 3'd3;
			off1_8 = R4_W'(3 * DAYS_YEAR);
		end else if (rem4_s7 >= R4_W'(2 * DAYS_YEAR)) begin
			c1_8   = 3'd2;
			off1_8 = R4_W'(2 * DAYS_YEAR);
		end else if (rem4_s7 >= R4_W'(DAYS_YEAR)) begin
			c1_8   = 3'd1;
			off1_8 = R4_W'(DAYS_YEAR);
		end else begin
			c1_8   = 3'd0;
			off1_8 = '0;
		end
	end

	// Stage 9: five-month groups within the March-based year.
	always_comb begin
		if (rem1_s8 >= R1_W'(2 * DAYS_5MON)) begin
			c5_9   = 2'd2;
			off5_9 = R1_W'(2 * DAYS_5MON);
		end else if (rem1_s8 >= R1_W'(DAYS_5MON)) begin
			c5_9   = 2'd1;
			off5_9 = R1_W'(DAYS_5MON);
		end else begin
			c5_9   = 2'd0;
			off5_9 = '0;
		end
	end

	// Stage 10: two-month groups within the five-month group.
	always_comb begin
		if (r5_s9 >= R5_W'(2 * DAYS_2MON)) begin
			c2_10   = 2'd2;
			off2_10 = R5_W'(2 * DAYS_2MON);
		end else if (r5_s9 >= R5_W'(DAYS_2MON)) begin
			c2_10   = 2'd1;
			off2_10 = R5_W'(DAYS_2MON);
		end else begin
			c2_10   = 2'd0;
			off2_10 = '0;
		end
	end

	// Stage 11: pick the month of the pair and the day within it.
	assign c31_11  = r2_s10 >= R2_W'(DAYS_LONG_MON);
	assign dom0_11 = c31_11 ? (r2_s10 - R2_W'(DAYS_LONG_MON)) : r2_s10;
	assign m0_11   = 4'(c5_s10) * 4'(5) + 4'(c2_s10) * 4'(2) + 4'(c31_11);

	// Valid bits advance every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			v_s1  <= start;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// Payload registers of all stages.
	always_ff @(posedge clk) begin
		u_s1      <= u_wide_1[U_W-1:0];

		q_s2      <= prod400_2[Q400_LSB +: CYC_W];
		ulow_s2   <= u_s1[REM0_W-1:0];

		rem0_s3   <= ulow_s2 - qmul_3[REM0_W-1:0];
		q_s3      <= q_s2;

		rem_s4    <= rem_4;
		q_s4      <= q_4;

		rem100_s5 <= R100_W'(rem_s4 - off100_5);
		c100_s5   <= c100_5;
		leap_s5   <= ge4_5;
		y_s5      <= YEAR_W'(q_s4) * YEAR_W'(YEARS_400) - YEAR_W'(YEAR_BIAS);

		rem100_s6 <= rem100_s5;
		c4_s6     <= prod4_6[RECIP_4Y_SHIFT +: C4_W];
		leap_s6   <= leap_s5;
		y_s6      <= y_s5 + YEAR_W'(c100_s5) * YEAR_W'(YEARS_100);

		rem4_s7   <= rem4_wide_7[R4_W-1:0];
		leap_s7   <= leap_s6;
		y_s7      <= y_s6 + YEAR_W'(c4_s6) * YEAR_W'(YEARS_4);

		rem1_s8   <= R1_W'(rem4_s7 - off1_8);
		leap_s8   <= leap_s7 | (c1_8 == 3'd4);
		y_s8      <= y_s7 + YEAR_W'(c1_8);

		c5_s9     <= c5_9;
		r5_s9     <= R5_W'(rem1_s8 - off5_9);
		leap_s9   <= leap_s8;
		y_s9      <= y_s8;

		c5_s10    <= c5_s9;
		c2_s10    <= c2_10;
		r2_s10    <= R2_W'(r5_s9 - off2_10);
		leap_s10  <= leap_s9;
		y_s10     <= y_s9;

		// January and February belong to the next year; a leap day at the
		// end of a cycle already names its year.
		if (leap_s10) begin
			month_s11 <= MONTH_W'(MONTH_FEB);
			day_s11   <= DAY_W'(DAY_LEAP);
			y_s11     <= y_s10;
		end else if (m0_11 > 4'(MONTHS_YEAR - MONTH_OFFSET)) begin
			month_s11 <= m0_11 - 4'(MONTHS_YEAR - MONTH_OFFSET);
			day_s11   <= DAY_W'(dom0_11) + DAY_W'(1);
			y_s11     <= y_s10 + YEAR_W'(1);
		end else begin
			month_s11 <= m0_11 + 4'(MONTH_OFFSET);
			day_s11   <= DAY_W'(dom0_11) + DAY_W'(1);
			y_s11     <= y_s10;
		end
	end

	// Result ports.
	assign done  = v_s11;
	assign year  = y_s11;
	assign month = month_s11;
	assign day   = day_s11;

endmodule
